### design/point_in_polygon_test_macros.svh
// Assertion macros for the point-in-polygon test block.
// Used by design/point_in_polygon_test.sv; expects clk_i and rst_ni in scope.
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define PIT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset.
`define PIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PIT_ASSERT(lbl, ante, cons, msg)
`define PIT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### design/pit_pkg.sv
// Shared types and constants of the point-in-polygon test block.
// No dependencies.
package pit_pkg;

  localparam int unsigned CoordW      = 16;  // width of point_x / point_y ports
  localparam int unsigned IndexW      = 6;   // width of vertex_index port
  localparam int unsigned CountW      = 7;   // width of vertex_count register
  localparam int unsigned MinVertices = 3;   // fewer vertices: always outside

  typedef enum logic {
    CmdWrite = 1'b0,
    CmdQuery = 1'b1
  } cmd_e;

endpackage

### design/pit_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pit_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/point_in_polygon_test.sv
// Point-in-polygon test by even-odd ray casting over a stored vertex list.
// Depends on pit_pkg, pit_ram and point_in_polygon_test_macros.svh.
//
//   Channel  Direction  Handshake                   Payload
//   in       request in in_valid_i / in_ready_o     command, vertex_index, point_x, point_y
//   out      result out out_valid_o / out_ready_i   inside_res
//   cfg      write in   cfg_valid_i / cfg_ready_o   cfg_vertex_count_i
//
// A write request stores its vertex in the cycle it is accepted and is done.
// A query with n = min(vertex_count, MAX_VERTICES) >= 3 makes n + 1 reads of the
// vertex RAM, one per cycle (its single read port sets the pace), then the three
// pipeline stages drain and the result loads. in_ready_o rises again together with
// the loaded result.
// A query with fewer than three vertices goes straight to the done state and loads "outside".
// Reset clears the control state and vertex_count; the RAM is not cleared.
// A full output register stalls the loading of the next query result, and with it in_ready_o.
`include "point_in_polygon_test_macros.svh"

module point_in_polygon_test
  import pit_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned COORD_BITS   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              command_i,
  input  logic [IndexW-1:0] vertex_index_i,
  input  logic [CoordW-1:0] point_x_i,
  input  logic [CoordW-1:0] point_y_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              inside_res_o,
  // configuration channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CountW-1:0] cfg_vertex_count_i
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);      // RAM address width
  localparam int unsigned NW = $clog2(MAX_VERTICES + 1);  // vertex count width
  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned DW = COORD_BITS + 1;            // signed difference
  localparam int unsigned PW = 2 * DW;                    // product width

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StIssue = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [CountW-1:0] count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i) begin
      count_q <= cfg_vertex_count_i;
    end
  end

  // Saturate the vertex count to the store's capacity.
  logic [NW-1:0] n_sat;
  always_comb begin
    if (32'(count_q) > 32'(MAX_VERTICES)) begin
      n_sat = NW'(MAX_VERTICES);
    end else begin
      n_sat = NW'(count_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic [1:0]    state_q, state_d;
  logic [NW-1:0] iss_q, iss_d;
  logic [NW-1:0] n_q;
  logic [CW-1:0] px_q, py_q;
  logic          accept, acc_query, acc_write;
  logic          pipe_busy;
  logic          out_valid_q, out_valid_d;
  logic          out_res_q;
  logic          parity_q;
  logic          rd_vld_q, rd_first_q;
  logic          s1_vld_q, s2_vld_q;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign acc_query  = accept && (cmd_e'(command_i) == CmdQuery);
  assign acc_write  = accept && (cmd_e'(command_i) == CmdWrite);
  assign pipe_busy  = rd_vld_q || s1_vld_q || s2_vld_q;

  always_comb begin
    state_d     = state_q;
    iss_d       = iss_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        if (acc_query) begin
          iss_d = '0;
          // too few vertices: answer outside straight away
          state_d = (n_sat < NW'(MinVertices)) ? StDone : StIssue;
        end
      end
      StIssue: begin
        if (iss_q == n_q) begin
          state_d = StDrain;
        end else begin
          iss_d = iss_q + NW'(1);
        end
      end
      StDrain: begin
        if (!pipe_busy) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      iss_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the query point and vertex count for the whole walk.
  always_ff @(posedge clk_i) begin
    if (acc_query) begin
      px_q <= CW'(point_x_i);
      py_q <= CW'(point_y_i);
      n_q  <= n_sat;
    end
    if ((state_q == StDone) && (!out_valid_q || out_ready_i)) begin
      out_res_q <= parity_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = out_res_q;

  // ---------------------------------------------------------------------------
  // Vertex RAM: {y, x} per entry. Writes only while idle, reads only during a
  // walk, so the two ports never touch the same entry in one cycle.
  // ---------------------------------------------------------------------------
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [2*CW-1:0] ram_wdata, ram_rdata;

  assign ram_we    = acc_write && (32'(vertex_index_i) < 32'(MAX_VERTICES));
  assign ram_waddr = AW'(vertex_index_i);
  assign ram_wdata = {CW'(point_y_i), CW'(point_x_i)};
  assign ram_re    = (state_q == StIssue);
  // First read fetches the last vertex, which seeds the wrap-around edge.
  assign ram_raddr = (iss_q == '0) ? AW'(n_q - NW'(1)) : AW'(iss_q - NW'(1));

  pit_ram #(
    .Width(2 * CW),
    .Depth(MAX_VERTICES)
  ) u_vertex_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Edge pipeline: read data -> differences -> products -> compare and toggle
  // ---------------------------------------------------------------------------
  logic [CW-1:0] cur_x, cur_y, prev_x_q, prev_y_q;
  logic          straddle;
  logic signed [DW-1:0] a_d, dy_d, b_d, c_d;
  logic signed [DW-1:0] s1_a_q, s1_dy_q, s1_b_q, s1_c_q;
  logic          s1_cross_q, s1_pos_q, s2_pos_q;
  logic signed [PW-1:0] lhs_q, rhs_q;
  logic          edge_hit;

  assign cur_x = ram_rdata[CW-1:0];
  assign cur_y = ram_rdata[2*CW-1:CW];

  // Current vertex is i, previous is j.
  assign straddle = (cur_y > py_q) != (prev_y_q > py_q);
  assign a_d  = $signed({1'b0, px_q})     - $signed({1'b0, cur_x});
  assign dy_d = $signed({1'b0, prev_y_q}) - $signed({1'b0, cur_y});
  assign b_d  = $signed({1'b0, prev_x_q}) - $signed({1'b0, cur_x});
  assign c_d  = $signed({1'b0, py_q})     - $signed({1'b0, cur_y});

  // Flip the comparison for edges that run downwards.
  assign edge_hit = s2_pos_q ? (lhs_q < rhs_q) : (lhs_q > rhs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      rd_first_q <= 1'b0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      parity_q   <= 1'b0;
    end else begin
      rd_vld_q   <= ram_re;
      rd_first_q <= ram_re && (iss_q == '0);
      s1_vld_q   <= rd_vld_q && !rd_first_q;
      s2_vld_q   <= s1_vld_q && s1_cross_q;
      if (acc_query) begin
        parity_q <= 1'b0;
      end else if (s2_vld_q && edge_hit) begin
        parity_q <= !parity_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prev_x_q   <= cur_x;
      prev_y_q   <= cur_y;
      s1_cross_q <= straddle;
      s1_pos_q   <= !dy_d[DW-1];
      s1_a_q     <= a_d;
      s1_dy_q    <= dy_d;
      s1_b_q     <= b_d;
      s1_c_q     <= c_d;
    end
    if (s1_vld_q) begin
      lhs_q    <= PW'(s1_a_q) * PW'(s1_dy_q);
      rhs_q    <= PW'(s1_b_q) * PW'(s1_c_q);
      s2_pos_q <= s1_pos_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PIT_ASSERT_NEXT(a_query_leaves_idle, acc_query, state_q != StIdle,
                   "accepted query did not start a walk")
  `PIT_ASSERT(a_pipe_empty_idle, state_q == StIdle, !pipe_busy,
              "edge pipeline active while idle")
  `PIT_ASSERT(a_issue_bound, state_q == StIssue, iss_q <= n_q,
              "read counter ran past the vertex count")
  `PIT_ASSERT(a_result_from_done, $rose(out_valid_q), $past(state_q) == StDone,
              "result loaded outside the done state")

endmodule

### tb/tb_point_in_polygon_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for point_in_polygon_test: vertex writes, vertex_count settings and
// ray-cast queries, checked against a predictor of the even-odd rule kept in a scoreboard class.
// Depends on pit_pkg and the point_in_polygon_test RTL only.

module tb_point_in_polygon_test
  import pit_pkg::*;
;

  localparam int unsigned MaxVertices = 64;
  // A query walks up to MaxVertices + 1 RAM reads plus a three-stage drain; allow some margin.
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned RandomItems = 600;
  localparam int unsigned TimeoutNs   = 2_000_000;

  // Predictor and store of expected inside flags
  class polygon_scoreboard;
    logic [CoordW-1:0] vert_x [MaxVertices];
    logic [CoordW-1:0] vert_y [MaxVertices];
    int unsigned       vertex_count;
    bit                inside_q [$];
    int unsigned       errors, requests, writes, queries, inside_hits;

    function void set_vertex_count(int unsigned value);
      vertex_count = value;
    endfunction

    function int unsigned pending();
      return inside_q.size();
    endfunction

    // Apply an accepted request: store the vertex, or cast the ray and queue the answer.
    function void note_request(cmd_e cmd, logic [IndexW-1:0] idx,
                               logic [CoordW-1:0] px, logic [CoordW-1:0] py);
      int unsigned n;
      int unsigned prev;
      bit          in_poly;
      longint      xa, ya, xb, yb, dy, lhs, rhs, qx, qy;
      requests++;
      if (cmd == CmdWrite) begin
        vert_x[idx] = px;
        vert_y[idx] = py;
        writes++;
      end else begin
        n       = (vertex_count > MaxVertices) ? MaxVertices : vertex_count;
        in_poly = 1'b0;
        qx      = longint'(px);
        qy      = longint'(py);
        if (n >= MinVertices) begin
          prev = n - 1;
          for (int unsigned i = 0; i < n; i++) begin
            xa = longint'(vert_x[i]);
            ya = longint'(vert_y[i]);
            xb = longint'(vert_x[prev]);
            yb = longint'(vert_y[prev]);
            // edge straddles the ray when exactly one end lies strictly above it
            if ((ya > qy) != (yb > qy)) begin
              dy  = yb - ya;
              lhs = (qx - xa) * dy;
              rhs = (xb - xa) * (qy - ya);
              if ((dy > 0) ? (lhs < rhs) : (lhs > rhs)) in_poly = !in_poly;
            end
            prev = i;
          end
        end
        inside_q.insert(inside_q.size(), in_poly);
        queries++;
      end
    endfunction

    function void check_result(logic got);
      bit want;
      if (inside_q.size() == 0) begin
        errors++;
        $display("%0t: inside_res %0b with no query outstanding, expected none", $time, got);
      end else begin
        want = inside_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: inside_res mismatch, expected %0b, actual %0b", $time, want, got);
        end else if (got) begin
          inside_hits++;
        end
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              command_i;
  logic [IndexW-1:0] vertex_index_i;
  logic [CoordW-1:0] point_x_i;
  logic [CoordW-1:0] point_y_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              inside_res_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CountW-1:0] cfg_vertex_count_i;

  polygon_scoreboard sb;

  // Sender burst state, shared by the request tasks
  int unsigned burst_left;
  // Raised by the stimulus to ask the receiver for one long hold-off
  bit          hold_results;
  int unsigned settings;
  // Polygon in use: effective vertex count, bounding box and grid pitch (0 = no grid)
  int unsigned n_eff;
  int unsigned box_x, box_w, box_y, box_h, grid_pitch;

  point_in_polygon_test uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .vertex_index_i    (vertex_index_i),
    .point_x_i         (point_x_i),
    .point_y_i         (point_y_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .inside_res_o      (inside_res_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_vertex_count_i(cfg_vertex_count_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #(TimeoutNs);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Check every result that crosses the output handshake
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(inside_res_o);
  end

  // Receiver: alternate ready segments of random length, with long open stretches, and honour a
  // single long hold-off when the stimulus asks for one. The hold is counted here, per cycle.
  initial begin
    int unsigned hold_left;
    int unsigned seg_left;
    bit          seg_val;
    hold_left   = 0;
    seg_left    = 0;
    seg_val     = 1'b0;
    out_ready_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        hold_left    = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          if ($urandom_range(0, 9) < 3) begin
            seg_val  = 1'b1;
            seg_left = $urandom_range(20, 80);
          end else begin
            seg_val  = 1'($urandom_range(0, 1));
            seg_left = $urandom_range(1, 8);
          end
        end
        seg_left--;
        out_ready_i <= seg_val;
      end
      @(posedge clk_i);
    end
  end

  // Offer one request and hold it until accepted. Between bursts drop valid for a random gap.
  task automatic send_request(input cmd_e cmd, input int unsigned idx,
                              input int unsigned x, input int unsigned y);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    vertex_index_i <= idx[IndexW-1:0];
    point_x_i      <= x[CoordW-1:0];
    point_y_i      <= y[CoordW-1:0];
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(cmd, idx[IndexW-1:0], x[CoordW-1:0], y[CoordW-1:0]);
  endtask

  // Drop valid and hold off until every outstanding query has answered.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Change vertex_count only with the block idle: drain, let the pipeline settle, then write.
  task automatic write_vertex_count(input int unsigned value);
    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i        <= 1'b1;
    cfg_vertex_count_i <= value[CountW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_vertex_count(value);
    n_eff      = (value > MaxVertices) ? MaxVertices : value;
    burst_left = 0;
    settings++;
  endtask

  // Coordinate within [lo, lo + w], snapped to the grid when one is in use
  function automatic int unsigned pick_coord(int unsigned lo, int unsigned w, int unsigned pitch);
    if (pitch != 0) return lo + pitch * $urandom_range(0, w / pitch);
    return lo + $urandom_range(0, w);
  endfunction

  // Pick a bounding box and style, then write vertices 0 .. n-1 as one sequence.
  task automatic load_polygon(input int unsigned n);
    int unsigned style;
    int unsigned x, y, r;
    style = $urandom_range(0, 3);
    r     = $urandom_range(0, 2);
    box_w = (r == 0) ? $urandom_range(16, 255) : (r == 1) ? $urandom_range(256, 16383) : 65535;
    r     = $urandom_range(0, 2);
    box_h = (r == 0) ? $urandom_range(16, 255) : (r == 1) ? $urandom_range(256, 16383) : 65535;
    box_x = $urandom_range(0, 65535 - box_w);
    box_y = $urandom_range(0, 65535 - box_h);
    // a coarse grid gives shared y values: horizontal edges and collinear runs
    grid_pitch = (style == 1) ? ((box_w < box_h ? box_w : box_h) / 6 + 1) : 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (style == 2) begin
        // full-scale corners mixed with random points
        r = $urandom_range(0, 2);
        x = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(0, 65535);
        r = $urandom_range(0, 2);
        y = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(0, 65535);
      end else begin
        x = pick_coord(box_x, box_w, grid_pitch);
        y = pick_coord(box_y, box_h, grid_pitch);
      end
      send_request(CmdWrite, i, x, y);
    end
    if (style == 2) begin
      box_x = 0;
      box_w = 65535;
      box_y = 0;
      box_h = 65535;
    end
  endtask

  // One query aimed at the current polygon: inside its box, on its vertices, on their rows and
  // columns, at the corners of the plane, or anywhere.
  task automatic random_query();
    int unsigned mode;
    int unsigned slot;
    int unsigned x, y;
    mode = $urandom_range(0, 99);
    slot = (n_eff > 0) ? $urandom_range(0, n_eff - 1) : 0;
    x    = pick_coord(box_x, box_w, grid_pitch);
    y    = pick_coord(box_y, box_h, grid_pitch);
    if (n_eff >= MinVertices && mode < 10) begin
      x = 32'(sb.vert_x[slot]);
      y = 32'(sb.vert_y[slot]);
    end else if (n_eff >= MinVertices && mode < 25) begin
      y = 32'(sb.vert_y[slot]);
    end else if (n_eff >= MinVertices && mode < 35) begin
      x = 32'(sb.vert_x[slot]);
    end else if (mode < 50) begin
      x = $urandom_range(0, 65535);
      y = $urandom_range(0, 65535);
    end else if (mode < 60) begin
      x = $urandom_range(0, 1) ? 65535 : 0;
      y = $urandom_range(0, 1) ? 65535 : 0;
    end
    send_request(CmdQuery, $urandom_range(0, 63), x, y);
  endtask

  // Main stimulus
  initial begin
    int unsigned phase;
    int unsigned count;
    int unsigned n_queries;
    int unsigned start_requests;
    int unsigned r;
    sb                 = new();
    burst_left         = 0;
    hold_results       = 1'b0;
    settings           = 0;
    n_eff              = 0;
    box_x              = 0;
    box_w              = 65535;
    box_y              = 0;
    box_h              = 65535;
    grid_pitch         = 0;
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    command_i          = CmdWrite;
    vertex_index_i     = '0;
    point_x_i          = '0;
    point_y_i          = '0;
    cfg_valid_i        = 1'b0;
    cfg_vertex_count_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: vertex_count from reset is zero, so any query answers outside
    send_request(CmdQuery, 0, 16'h8000, 16'h8000);
    // square 0x1000..0xF000 in slots 0..3
    send_request(CmdWrite, 0, 16'h1000, 16'h1000);
    send_request(CmdWrite, 1, 16'hF000, 16'h1000);
    send_request(CmdWrite, 2, 16'hF000, 16'hF000);
    send_request(CmdWrite, 3, 16'h1000, 16'hF000);
    // one and two vertices: still outside
    write_vertex_count(1);
    send_request(CmdQuery, 0, 16'h8000, 16'h8000);
    write_vertex_count(2);
    send_request(CmdQuery, 0, 16'h8000, 16'h8000);
    // full square: centre, plane corners, points on horizontal and vertical edges, a vertex
    write_vertex_count(4);
    send_request(CmdQuery, 0, 16'h8000, 16'h8000);
    send_request(CmdQuery, 0, 16'h0000, 16'h0000);
    send_request(CmdQuery, 63, 16'hFFFF, 16'hFFFF);
    send_request(CmdQuery, 0, 16'h8000, 16'h1000);
    send_request(CmdQuery, 0, 16'h8000, 16'hF000);
    send_request(CmdQuery, 0, 16'h1000, 16'h1000);
    send_request(CmdQuery, 0, 16'h1000, 16'h8000);
    send_request(CmdQuery, 0, 16'hF000, 16'h8000);
    send_request(CmdQuery, 0, 16'h1001, 16'h1001);
    send_request(CmdQuery, 0, 16'h0800, 16'h8000);
    // triangle from the first three corners: the closing edge is a diagonal
    write_vertex_count(3);
    send_request(CmdQuery, 0, 16'hC000, 16'h4000);
    send_request(CmdQuery, 0, 16'h4000, 16'hC000);
    // extreme coordinates and the top slot
    send_request(CmdWrite, 63, 16'hFFFF, 16'h0000);
    send_request(CmdWrite, 4, 16'h0000, 16'hFFFF);
    write_vertex_count(5);
    send_request(CmdQuery, 0, 16'h8000, 16'h8000);
    send_request(CmdQuery, 0, 16'h0000, 16'hFFFF);

    // Random: each phase sets a count, loads a fresh polygon and queries it, with stray writes
    // mixed in. The first phases walk the register extremes; most later ones keep n small.
    start_requests = sb.requests;
    phase          = 0;
    while (sb.requests - start_requests < RandomItems) begin
      case (phase)
        0: count = 3;
        1: count = 127;
        2: count = 64;
        3: count = 0;
        4: count = 65;
        5: count = 1;
        6: count = 2;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 60)      count = $urandom_range(3, 8);
          else if (r < 80) count = $urandom_range(9, 32);
          else if (r < 90) count = $urandom_range(33, 64);
          else if (r < 95) count = $urandom_range(65, 127);
          else             count = $urandom_range(0, 2);
        end
      endcase
      write_vertex_count(count);
      if (n_eff >= MinVertices) begin
        load_polygon(n_eff);
      end else begin
        repeat ($urandom_range(0, 3))
          send_request(CmdWrite, $urandom_range(0, 63), $urandom_range(0, 65535),
                       $urandom_range(0, 65535));
      end
      n_queries = $urandom_range(8, 30);
      if (phase == 0) begin
        // fill the block behind a long receiver hold-off, offering requests back to back
        hold_results = 1'b1;
        burst_left   = 64;
        n_queries    = 40;
      end
      repeat (n_queries) begin
        if ($urandom_range(0, 99) < 12)
          send_request(CmdWrite, $urandom_range(0, 63), $urandom_range(0, 65535),
                       $urandom_range(0, 65535));
        else
          random_query();
      end
      phase++;
    end

    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Run covered %0d requests (%0d vertex writes, %0d queries, %0d inside) over %0d",
             sb.requests, sb.writes, sb.queries, sb.inside_hits, settings);
    $display("vertex_count settings, with %0d mismatches.", sb.errors);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
